/* src/hashed_block_cache_lru_core_macros.svh */
// Assertion shorthands used by the checker file hbc_checker.sv.
// Each macro expects clk and rst_n in scope.
`ifndef HASHED_BLOCK_CACHE_LRU_CORE_MACROS_SVH
`define HASHED_BLOCK_CACHE_LRU_CORE_MACROS_SVH

// Same-cycle implication.
`define HBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/hbc_pkg.sv */
package hbc_pkg;

    // Field widths fixed by the interface
    localparam int BLK_W  = 32;
    localparam int DEV_W  = 8;
    localparam int CNT_W  = 8;
    localparam int TICK_W = 32;

    // Block-number remainder: bits folded per step and number of steps
    localparam int MOD_BITS  = 8;
    localparam int MOD_STEPS = BLK_W / MOD_BITS;

    // Commands
    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_HIT       = 3'd0;
    localparam logic [2:0] ST_MISS      = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_RELEASED  = 3'd3;
    localparam logic [2:0] ST_UNDERFLOW = 3'd4;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic              command;
        logic [DEV_W-1:0]  device_id;
        logic [BLK_W-1:0]  block_number;
        logic [2:0]        release_way;
        logic [TICK_W-1:0] now_tick;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [4:0]       set_index;
        logic [2:0]       way_index;
        logic [CNT_W-1:0] ref_count;
    } rsp_t;

    // One way of a set row
    typedef struct packed {
        logic [DEV_W-1:0]  dev;
        logic [BLK_W-1:0]  blk;
        logic [CNT_W-1:0]  cnt;
        logic [TICK_W-1:0] rel_time;
    } way_entry_t;

    // Controller to datapath
    typedef struct packed {
        logic load_req;
        logic mod_step;
        logic mem_read;
        logic look;
        logic scan_step;
        logic commit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_release;
        logic hit;
        logic scan_last;
        logic out_free;
    } dp_stat_t;

endpackage

/* src/hbc_ctrl.sv */
module hbc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  hbc_pkg::dp_stat_t stat,
    output hbc_pkg::dp_cmd_t  cmd
);
    import hbc_pkg::*;

    localparam int MOD_CNT_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_LOOK = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [MOD_CNT_W-1:0] step_reg, step_next;

    // Take a request only between items
    assign req_stall = (state_reg != S_IDLE);

    // Sequence one item through remainder, row read, lookup, victim scan, commit
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    step_next    = '0;
                    state_next   = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == MOD_CNT_W'(MOD_STEPS - 1))
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = S_LOOK;
            end
            S_LOOK:
            begin
                cmd.look = 1'b1;
                if (stat.is_release || stat.hit)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // Hold until the result register can take the beat
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

/* src/hbc_dp.sv */
module hbc_dp #(
    parameter int NUM_SETS = 31,
    parameter int NUM_WAYS = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hbc_pkg::req_t     req_data,
    input  hbc_pkg::dp_cmd_t  cmd,
    output hbc_pkg::dp_stat_t stat,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output hbc_pkg::rsp_t     rsp_data
);
    import hbc_pkg::*;

    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam logic [SET_W:0] SETS_V = (SET_W + 1)'(NUM_SETS);

    typedef way_entry_t [NUM_WAYS-1:0] row_t;

    // Set rows, one per set; rows never written read as all zero
    row_t             mem [NUM_SETS];
    logic [NUM_SETS-1:0] row_valid_reg;

    // Request fields
    logic              cmd_reg;
    logic [DEV_W-1:0]  dev_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [BLK_W-1:0]  blk_sh_reg;
    logic [2:0]        rway_reg;
    logic [TICK_W-1:0] tick_reg;
    logic [SET_W-1:0]  set_reg;

    // Row read and working copy
    row_t              rdata_reg;
    logic              rvld_reg;
    row_t              row_view;
    row_t              row_reg;
    row_t              row_rot;
    row_t              row_new;

    // Lookup and victim scan
    logic              hit_now;
    logic [WAY_W-1:0]  hit_way_now;
    logic              hit_reg;
    logic [WAY_W-1:0]  hit_way_reg;
    logic [WAY_W-1:0]  scan_way_reg;
    logic              found_reg;
    logic [TICK_W-1:0] best_reg;
    logic [WAY_W-1:0]  pick_reg;
    logic              take_now;

    // Commit
    logic              rel_ok;
    logic [WAY_W-1:0]  tw;
    way_entry_t        cur;
    way_entry_t        ent;
    rsp_t              res;

    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    // Fold MOD_BITS bits of the block number into the running remainder
    function automatic logic [SET_W-1:0] fold_bits(
        input logic [SET_W-1:0]    r_in,
        input logic [MOD_BITS-1:0] d
    );
        logic [SET_W:0] acc;
        acc = {1'b0, r_in};
        for (int i = MOD_BITS - 1; i >= 0; i--)
        begin
            acc = {acc[SET_W-1:0], d[i]};
            if (acc >= SETS_V)
            begin
                acc = acc - SETS_V;
            end
        end
        return acc[SET_W-1:0];
    endfunction

    // Gate unwritten rows to zero
    assign row_view = rvld_reg ? rdata_reg : '0;

    // Compare all ways in parallel, lowest way wins
    always_comb
    begin
        hit_now     = 1'b0;
        hit_way_now = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (row_view[w].dev == dev_reg && row_view[w].blk == blk_reg)
            begin
                hit_now     = 1'b1;
                hit_way_now = WAY_W'(w);
            end
        end
    end

    // Rotate the row so the way under scan sits at position zero
    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            row_rot[w] = row_reg[(w + 1) % NUM_WAYS];
        end
    end

    assign take_now = (row_reg[0].cnt == '0) &&
                      (!found_reg || (row_reg[0].rel_time < best_reg));

    // Pick the target way and build the updated entry and result
    assign rel_ok = (32'(rway_reg) < 32'(NUM_WAYS));

    always_comb
    begin
        if (cmd_reg == CMD_RELEASE)
        begin
            tw = rel_ok ? WAY_W'(rway_reg) : '0;
        end
        else if (hit_reg)
        begin
            tw = hit_way_reg;
        end
        else
        begin
            tw = pick_reg;
        end
        cur = row_reg[tw];
        ent = cur;
        res.set_index = 5'(set_reg);
        res.way_index = 3'(tw);
        res.ref_count = '0;
        if (cmd_reg == CMD_RELEASE)
        begin
            res.way_index = rway_reg;
            if (!rel_ok || cur.cnt == '0)
            begin
                res.status = ST_UNDERFLOW;
            end
            else
            begin
                ent.cnt = cur.cnt - 1'b1;
                if (ent.cnt == '0)
                begin
                    ent.rel_time = tick_reg;
                end
                res.status    = ST_RELEASED;
                res.ref_count = ent.cnt;
            end
        end
        else if (hit_reg)
        begin
            ent.cnt       = (cur.cnt == CNT_MAX) ? cur.cnt : cur.cnt + 1'b1;
            res.status    = ST_HIT;
            res.ref_count = ent.cnt;
        end
        else if (found_reg)
        begin
            ent.dev       = dev_reg;
            ent.blk       = blk_reg;
            ent.cnt       = CNT_W'(1);
            res.status    = ST_MISS;
            res.ref_count = ent.cnt;
        end
        else
        begin
            res.status    = ST_FULL;
            res.way_index = '0;
        end
        row_new     = row_reg;
        row_new[tw] = ent;
    end

    // Status to the controller
    assign stat.is_release = (cmd_reg == CMD_RELEASE);
    assign stat.hit        = hit_now;
    assign stat.scan_last  = (scan_way_reg == WAY_W'(NUM_WAYS - 1));
    assign stat.out_free   = !rsp_valid_reg || !rsp_stall;

    // Row memory: one read and one write port
    always_ff @(posedge clk)
    begin
        if (cmd.mem_read)
        begin
            rdata_reg <= mem[set_reg];
        end
        if (cmd.commit)
        begin
            mem[set_reg] <= row_new;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            cmd_reg    <= req_data.command;
            dev_reg    <= req_data.device_id;
            blk_reg    <= req_data.block_number;
            blk_sh_reg <= req_data.block_number;
            rway_reg   <= req_data.release_way;
            tick_reg   <= req_data.now_tick;
            set_reg    <= '0;
        end
        if (cmd.mod_step)
        begin
            set_reg    <= fold_bits(set_reg, blk_sh_reg[BLK_W-1 -: MOD_BITS]);
            blk_sh_reg <= blk_sh_reg << MOD_BITS;
        end
        if (cmd.mem_read)
        begin
            rvld_reg <= row_valid_reg[set_reg];
        end
        if (cmd.look)
        begin
            row_reg      <= row_view;
            hit_reg      <= hit_now;
            hit_way_reg  <= hit_way_now;
            scan_way_reg <= '0;
            found_reg    <= 1'b0;
            best_reg     <= '0;
            pick_reg     <= '0;
        end
        if (cmd.scan_step)
        begin
            row_reg      <= row_rot;
            scan_way_reg <= scan_way_reg + 1'b1;
            if (take_now)
            begin
                found_reg <= 1'b1;
                best_reg  <= row_reg[0].rel_time;
                pick_reg  <= scan_way_reg;
            end
        end
        if (cmd.commit)
        begin
            rsp_reg <= res;
        end
    end

    // Row valid bits and result beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                row_valid_reg[set_reg] <= 1'b1;
                rsp_valid_reg          <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

/* src/hashed_block_cache_lru_core.sv */
// Channel   Handshake              Payload    Beat
// request   req_valid/req_stall    req_data   command, device, block, way, tick
// response  rsp_valid/rsp_stall    rsp_data   status, set, way, count
//
// A hit or a release goes through remainder steps, row read and lookup to commit; a miss
// also runs the victim scan first. The next request is taken the cycle after the commit,
// so a new item is taken only after the last one is committed to the output register.
// The block-number remainder folds 8 bits per cycle, and the victim
// search visits one way per cycle; the row memory is read once and written once.
// req_stall is high from accept until the result is committed to the output register.
// A stalled result holds and delays the next commit; reset clears row valid bits at once.
module hashed_block_cache_lru_core #(
    parameter int NUM_SETS = 31,
    parameter int NUM_WAYS = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  hbc_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output hbc_pkg::rsp_t rsp_data
);
    import hbc_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    hbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    hbc_dp #(
        .NUM_SETS (NUM_SETS),
        .NUM_WAYS (NUM_WAYS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

/* src/hbc_checker.sv */
`include "hashed_block_cache_lru_core_macros.svh"

module hbc_checker #(
    parameter int NUM_SETS = 31
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input hbc_pkg::rsp_t rsp_data
);
    import hbc_pkg::*;

    // One item in flight: an accepted beat closes the request side
    `HBC_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "request taken while busy")

    // A full set reports way zero and count zero
    `HBC_ASSERT_NOW(a_full_fields, rsp_valid && rsp_data.status == ST_FULL, rsp_data.way_index == 3'd0 && rsp_data.ref_count == '0, "full set fields wrong")

    // A fresh allocation holds one reference; an underflow reports none
    `HBC_ASSERT_NOW(a_count_code, rsp_valid && (rsp_data.status == ST_MISS || rsp_data.status == ST_UNDERFLOW), rsp_data.ref_count == ((rsp_data.status == ST_MISS) ? 8'd1 : 8'd0), "count does not match status")

    // Set index stays below the set count
    `HBC_ASSERT_NOW(a_set_range, rsp_valid, 32'(rsp_data.set_index) < 32'(NUM_SETS), "set index out of range")

    // A stalled result beat holds
    `HBC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response changed")

endmodule

bind hashed_block_cache_lru_core hbc_checker #(.NUM_SETS(NUM_SETS)) u_hbc_checker (.*);

/* test/hashed_block_cache_lru_core_check.sv */
`timescale 1ns / 1ps

module hashed_block_cache_lru_core_check #(
    parameter int NUM_SETS = 31,
    parameter int NUM_WAYS = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_stall,
    input  hbc_pkg::req_t req_data,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  hbc_pkg::rsp_t rsp_data,
    output int            fail_count,
    output int            outstanding
);

    import hbc_pkg::*;

    localparam int ENTRIES = NUM_SETS * NUM_WAYS;

    // Shadow copy of the tag store, one entry per set and way
    logic [DEV_W-1:0]  line_dev  [ENTRIES];
    logic [BLK_W-1:0]  line_blk  [ENTRIES];
    logic [CNT_W-1:0]  line_refs [ENTRIES];
    logic [TICK_W-1:0] line_freed[ENTRIES];

    rsp_t pending_results[$];

    // Apply one request to the shadow store and return the response it yields
    function automatic rsp_t cache_access(input req_t r);
        rsp_t              res;
        int                base;
        int                e;
        int                pick;
        logic              found;
        logic [TICK_W-1:0] oldest;
        res.set_index = 5'(r.block_number % NUM_SETS);
        base          = int'(res.set_index) * NUM_WAYS;
        found         = 1'b0;
        pick          = 0;
        oldest        = '0;
        if (r.command == CMD_ACQUIRE)
        begin
            // Search the set for a matching tag
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                e = base + w;
                if (line_dev[e] == r.device_id && line_blk[e] == r.block_number)
                begin
                    if (line_refs[e] != CNT_MAX)
                        line_refs[e] = line_refs[e] + 1'b1;
                    res.status    = ST_HIT;
                    res.way_index = 3'(w);
                    res.ref_count = line_refs[e];
                    return res;
                end
            end
            // Pick the free way released longest ago, lowest way on ties
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                e = base + w;
                if (line_refs[e] == '0 && (!found || line_freed[e] < oldest))
                begin
                    found  = 1'b1;
                    pick   = w;
                    oldest = line_freed[e];
                end
            end
            if (!found)
            begin
                res.status    = ST_FULL;
                res.way_index = '0;
                res.ref_count = '0;
                return res;
            end
            e             = base + pick;
            line_dev[e]   = r.device_id;
            line_blk[e]   = r.block_number;
            line_refs[e]  = CNT_W'(1);
            res.status    = ST_MISS;
            res.way_index = 3'(pick);
            res.ref_count = CNT_W'(1);
            return res;
        end
        // Release: way out of range or count already zero underflows
        res.way_index = r.release_way;
        if (r.release_way >= NUM_WAYS || line_refs[base + int'(r.release_way)] == '0)
        begin
            res.status    = ST_UNDERFLOW;
            res.ref_count = '0;
            return res;
        end
        e            = base + int'(r.release_way);
        line_refs[e] = line_refs[e] - 1'b1;
        if (line_refs[e] == '0)
            line_freed[e] = r.now_tick;
        res.status    = ST_RELEASED;
        res.ref_count = line_refs[e];
        return res;
    endfunction

    // Track both channels: check response beats first, then record new requests
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                line_dev[i]   = '0;
                line_blk[i]   = '0;
                line_refs[i]  = '0;
                line_freed[i] = '0;
            end
            pending_results.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected beat: status=%0d set=%0d way=%0d count=%0d",
                                 $realtime, rsp_data.status, rsp_data.set_index,
                                 rsp_data.way_index, rsp_data.ref_count);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_data.status !== want.status || rsp_data.set_index !== want.set_index
                        || rsp_data.way_index !== want.way_index
                        || rsp_data.ref_count !== want.ref_count)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: mismatch: expected status=%0d set=%0d way=%0d count=%0d",
                                     $realtime, want.status, want.set_index, want.way_index,
                                     want.ref_count);
                            $display("    got status=%0d set=%0d way=%0d count=%0d",
                                     rsp_data.status, rsp_data.set_index,
                                     rsp_data.way_index, rsp_data.ref_count);
                        end
                        fail_count++;
                    end
                end
            end
            if (req_valid && !req_stall)
                pending_results.push_back(cache_access(req_data));
            outstanding = pending_results.size();
        end
    end

endmodule

/* test/hashed_block_cache_lru_core_test.sv */
`timescale 1ns / 1ps

module hashed_block_cache_lru_core_test;

    import hbc_pkg::*;

    localparam int SETS         = 31;
    localparam int WAYS         = 5;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 270;
    localparam int HAMMER_ITEMS = 258;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data  = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;

    int          fail_count;
    int          outstanding;
    int          quiet_cycles = 0;
    int          idle_pct     = 0;
    int          stall_pct    = 0;
    logic [31:0] tick_now     = '0;

    hashed_block_cache_lru_core #(
        .NUM_SETS (SETS),
        .NUM_WAYS (WAYS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    hashed_block_cache_lru_core_check #(
        .NUM_SETS (SETS),
        .NUM_WAYS (WAYS)
    ) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Stall the response channel at random
    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    // End the run when no beat moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** hashed_block_cache_lru_core: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Present one request beat, with a random idle gap first, and hold until accepted
    task automatic send_request(input req_t item);
        if ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        req_data  <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic acquire(input logic [7:0] dev, input logic [31:0] blk,
                           input logic [31:0] tick);
        req_t item;
        item.command      = CMD_ACQUIRE;
        item.device_id    = dev;
        item.block_number = blk;
        item.release_way  = 3'($urandom_range(7));
        item.now_tick     = tick;
        send_request(item);
    endtask

    task automatic release_entry(input logic [31:0] blk, input logic [2:0] way,
                                 input logic [31:0] tick);
        req_t item;
        item.command      = CMD_RELEASE;
        item.device_id    = 8'($urandom_range(255));
        item.block_number = blk;
        item.release_way  = way;
        item.now_tick     = tick;
        send_request(item);
    endtask

    // Build a request that mostly lands in a few busy sets with a small pool of tags
    task automatic send_random_request();
        req_t        item;
        int unsigned set_pick;
        int unsigned roll;
        set_pick     = ($urandom_range(99) < 70) ? $urandom_range(3) : $urandom_range(SETS - 1);
        item.command = ($urandom_range(99) < 55) ? CMD_ACQUIRE : CMD_RELEASE;
        roll         = $urandom_range(9);
        case (roll)
            0:       item.device_id = 8'($urandom_range(255));
            1, 2:    item.device_id = 8'hFF;
            3, 4:    item.device_id = 8'h01;
            5:       item.device_id = 8'h02;
            default: item.device_id = 8'h00;
        endcase
        if ($urandom_range(9) == 0)
            item.block_number = $urandom;
        else if (item.command == CMD_RELEASE && $urandom_range(1) == 1)
            item.block_number = set_pick + SETS * $urandom_range(138547331);
        else
            item.block_number = set_pick + SETS * $urandom_range(7);
        if ($urandom_range(99) < 85)
            item.release_way = 3'($urandom_range(WAYS - 1));
        else
            item.release_way = 3'($urandom_range(7, WAYS));
        // Advance the tick, with occasional jumps to random and extreme values
        tick_now = tick_now + $urandom_range(1, 1000);
        roll     = $urandom_range(99);
        if (roll < 5)
            item.now_tick = $urandom;
        else if (roll < 8)
            item.now_tick = '1;
        else if (roll < 10)
            item.now_tick = '0;
        else
            item.now_tick = tick_now;
        send_request(item);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fresh store: device 0 block 0 hits, then count down through underflow
        acquire(8'h00, 32'd0, 32'd5);
        acquire(8'h00, 32'd0, 32'd6);
        release_entry(32'd0, 3'd0, 32'd7);
        release_entry(32'd0, 3'd0, 32'hFFFF_FFFF);
        release_entry(32'd0, 3'd0, 32'd9);
        release_entry(32'd0, 3'd7, 32'd10);
        release_entry(32'd31, 3'd5, 32'd11);
        release_entry(32'd62, 3'd6, 32'd12);
        acquire(8'hFF, 32'hFFFF_FFFF, 32'd13);
        // Fill one set, overflow it, then free a way whose release time is all ones
        acquire(8'h01, 32'd1, 32'd20);
        acquire(8'h01, 32'd32, 32'd21);
        acquire(8'h01, 32'd63, 32'd22);
        acquire(8'h01, 32'd94, 32'd23);
        acquire(8'h01, 32'd125, 32'd24);
        acquire(8'h01, 32'd156, 32'd25);
        release_entry(32'd1, 3'd2, 32'hFFFF_FFFF);
        acquire(8'h01, 32'd187, 32'd26);
        acquire(8'h01, 32'd32, 32'd27);
        release_entry(32'hFFFF_FFFF, 3'd4, 32'd0);

        // Drive one block past the saturating count
        repeat (HAMMER_ITEMS)
            acquire(8'hA5, 32'd30 + 32'd31 * 32'd1000, 32'd30);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 75;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 75;
                end
                default:
                begin
                    idle_pct  = 24;
                    stall_pct = 24;
                end
            endcase
            repeat (PHASE_ITEMS)
                send_random_request();
        end
        req_valid <= 1'b0;

        // Drain the remaining responses, then let the pipeline settle
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("** hashed_block_cache_lru_core: PASSED **");
        else
            $display("** hashed_block_cache_lru_core: FAILED **");
        $finish;
    end

endmodule
